// ===== design/gpc_pkg.sv =====
`default_nettype none
package gpc_pkg;

  localparam int MaxDof = 256;
  localparam int Terms = 6;
  localparam int DofW = 8;
  localparam int TermW = 3;
  localparam int AddrW = DofW + TermW;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_CORRECT = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] NEG_MAX = {1'b1, {47{1'b0}}};

  // One classified command, passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]         op;
    logic [DofW-1:0]    dof;
    logic signed [47:0] value_a;
    logic signed [47:0] value_b;
  } cmd_t;

  // Gear corrector gains, unsigned Q1.32 (term two has gain one and is
  // handled as a plain add).
  function automatic logic [32:0] gear_gain(input logic [2:0] j);
    logic [32:0] g;
    begin
      case (j)
        3'd0: g = 33'd805306368;
        3'd1: g = 33'd2994546642;
        3'd2: g = 33'h100000000;
        3'd3: g = 33'd2624702236;
        3'd4: g = 33'd715827883;
        3'd5: g = 33'd71582788;
        default: g = '0;
      endcase
      return g;
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
    logic signed [47:0] r;
    begin
      if (v > 54'sd140737488355327) r = POS_MAX;
      else if (v < -54'sd140737488355328) r = NEG_MAX;
      else r = v[47:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/gpc_front.sv =====
`default_nettype none
module gpc_front import gpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  dof_index,
  input  wire logic [47:0] value_a,
  input  wire logic [47:0] value_b,
  output logic             busy,
  output logic             q_valid,
  output cmd_t             q_cmd,
  input  wire logic        q_take
);

  // Two-entry queue of commands.
  cmd_t      slot [2];
  logic      rd_ptr;
  logic      wr_ptr;
  logic [1:0] count;
  logic      push;
  cmd_t      cmd_in;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = slot[rd_ptr];

  always_comb begin
    cmd_in.op      = op;
    cmd_in.dof     = dof_index;
    cmd_in.value_a = value_a;
    cmd_in.value_b = value_b;
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd_in;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_take) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end

endmodule
`default_nettype wire

// ===== design/gpc_back.sv =====
`default_nettype none
module gpc_back import gpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] time_step,
  input  wire logic [46:0] inverse_step,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_take,
  output logic             done,
  output logic [47:0]      delta_position,
  output logic [47:0]      velocity
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_RWAIT  = 4'd2;
  localparam logic [3:0] S_PRED   = 4'd3;
  localparam logic [3:0] S_ERR    = 4'd4;
  localparam logic [3:0] S_CORR   = 4'd5;
  localparam logic [3:0] S_VEL    = 4'd6;
  localparam logic [3:0] S_LOAD   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_WRITE  = 4'd10;

  // Multiplier phase at which the rounded product is ready to be used.
  localparam logic [2:0] MUL_DONE = 3'd5;

  // Vectors in memories, one word per term.
  logic [47:0] cmem [MaxDof*Terms];
  logic [47:0] pmem [MaxDof*Terms];

  logic [3:0]  state;
  cmd_t        cmd;
  logic [2:0]  j;
  logic [2:0]  rj;
  logic [47:0] crd, prd;
  logic signed [47:0] cv [Terms];
  logic signed [47:0] pv [Terms];
  logic signed [47:0] err;
  logic signed [47:0] dpos;
  logic [AddrW-1:0] base;

  // Shared rounding multiplier: magnitude times constant. The product is
  // built from four 24 by 32 partial products in phases zero to three,
  // rounded in phase four and used in phase five.
  logic signed [47:0] mx;
  logic [63:0]        mc;
  logic [6:0]         ms;
  logic               mneg;
  logic [111:0]       mprod;
  logic signed [47:0] mres;
  logic [2:0]         mphase;
  logic [23:0]        mop_a;
  logic [31:0]        mop_b;
  logic [55:0]        mpart;
  logic [6:0]         mshift;

  function automatic logic signed [47:0] round_sat(input logic [111:0] pr,
                                                   input logic [6:0] s,
                                                   input logic neg);
    logic [112:0] t;
    logic [112:0] q;
    logic signed [47:0] r;
    begin
      t = {1'b0, pr} + ({112'd0, 1'b1} << (s - 7'd1));
      q = t >> s;
      if (neg) begin
        if (q > 113'h800000000000) r = NEG_MAX;
        else r = -$signed(q[47:0]);
      end else begin
        if (q > 113'h7FFFFFFFFFFF) r = POS_MAX;
        else r = q[47:0];
      end
      return r;
    end
  endfunction

  logic [47:0] mag;
  logic [53:0] psum;
  logic [53:0] csum;
  logic [63:0] hdt2;

  assign base = AddrW'(cmd.dof) * AddrW'(Terms);
  assign hdt2 = ({32'd0, time_step} * {32'd0, time_step}) >> 1;

  always_comb begin
    mag = mx[47] ? 48'(-mx) : mx;
    mop_a = mphase[0] ? mag[47:24] : mag[23:0];
    mop_b = mphase[1] ? mc[63:32] : mc[31:0];
    mpart = {32'd0, mop_a} * {24'd0, mop_b};
    mshift = (mphase[0] ? 7'd24 : 7'd0) + (mphase[1] ? 7'd32 : 7'd0);
    psum = '0;
    case (j)
      3'd0: psum = 54'(cv[0]) + 54'(cv[1]) + 54'(cv[2]) + 54'(cv[3]) + 54'(cv[4])
                   + 54'(cv[5]);
      3'd1: psum = 54'(cv[1]) + 54'(cv[2]) * 54'sd2 + 54'(cv[3]) * 54'sd3
                   + 54'(cv[4]) * 54'sd4 + 54'(cv[5]) * 54'sd5;
      3'd2: psum = 54'(cv[2]) + 54'(cv[3]) * 54'sd3 + 54'(cv[4]) * 54'sd6
                   + 54'(cv[5]) * 54'sd10;
      3'd3: psum = 54'(cv[3]) + 54'(cv[4]) * 54'sd4 + 54'(cv[5]) * 54'sd10;
      3'd4: psum = 54'(cv[4]) + 54'(cv[5]) * 54'sd5;
      3'd5: psum = 54'(cv[5]);
      default: psum = '0;
    endcase
    csum = 54'(cv[1]) + 54'(cv[2]) + 54'(cv[3]) + 54'(cv[4]) + 54'(cv[5]);
  end

  assign q_take = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    crd <= cmem[base + AddrW'(rj)];
    prd <= pmem[base + AddrW'(rj)];
    if (mphase < 3'd4) begin
      mprod <= ((mphase == 3'd0) ? 112'd0 : mprod) + ({56'd0, mpart} << mshift);
    end
    mres <= round_sat(mprod, ms, mneg);
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          j <= 3'd0;
          rj <= 3'd0;
          if (q_cmd.op == OP_NONE || 9'(q_cmd.dof) >= 9'(MaxDof)) begin
            delta_position <= '0;
            velocity <= '0;
            state <= S_OUT;
          end else if (q_cmd.op == OP_LOAD) begin
            mx <= q_cmd.value_b; mneg <= q_cmd.value_b[47];
            mc <= {32'd0, time_step}; ms <= 7'd32;
            mphase <= 3'd0;
            state <= S_LOAD;
          end else state <= S_RD;
        end
        S_RD: begin
          rj <= rj + 3'd1;
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          cv[j] <= crd; pv[j] <= prd;
          if (j == 3'(Terms-1)) begin
            j <= 3'd0;
            if (cmd.op == OP_PREDICT) state <= S_PRED;
            else begin
              mx <= cmd.value_a; mneg <= cmd.value_a[47];
              mc <= hdt2; ms <= 7'd64; mphase <= 3'd0;
              state <= S_ERR;
            end
          end else begin
            j <= j + 3'd1;
            rj <= rj + 3'd1;
          end
        end
        S_PRED: begin
          pv[j] <= sat48(psum);
          if (j == 3'(Terms-1)) begin
            dpos <= sat48(csum);
            j <= 3'd0;
            state <= S_WRITE;
          end else j <= j + 3'd1;
        end
        S_ERR: begin
          mphase <= mphase + 3'd1;
          if (mphase == MUL_DONE) begin
            err <= sat48(54'(mres) - 54'(pv[2]));
            mx <= sat48(54'(mres) - 54'(pv[2]));
            mneg <= sat48(54'(mres) - 54'(pv[2])) < 0;
            mc <= {31'd0, gear_gain(3'd0)}; ms <= 7'd32;
            mphase <= 3'd0; j <= 3'd0;
            state <= S_CORR;
          end
        end
        S_CORR: begin
          mphase <= mphase + 3'd1;
          if (mphase == MUL_DONE) begin
            if (j == 3'd2) cv[j] <= sat48(54'(pv[j]) + 54'(err));
            else cv[j] <= sat48(54'(pv[j]) + 54'(mres));
            if (j == 3'd0) dpos <= mres;
            // The gain for the next term is in place before its product starts.
            mc <= {31'd0, gear_gain(j + 3'd1)};
            mphase <= 3'd0;
            if (j == 3'(Terms-1)) begin
              j <= 3'd0;
              state <= S_WRITE;
            end else j <= j + 3'd1;
          end
        end
        S_WRITE: begin
          cmem[base + AddrW'(j)] <= cv[j];
          pmem[base + AddrW'(j)] <= pv[j];
          if (j == 3'(Terms-1)) begin
            mx <= (cmd.op == OP_PREDICT) ? pv[1] : cv[1];
            mneg <= (cmd.op == OP_PREDICT) ? pv[1][47] : cv[1][47];
            mc <= {17'd0, inverse_step}; ms <= 7'd24; mphase <= 3'd0;
            state <= S_VEL;
          end else j <= j + 3'd1;
        end
        S_VEL: begin
          mphase <= mphase + 3'd1;
          if (mphase == MUL_DONE) begin
            delta_position <= dpos;
            velocity <= mres;
            state <= S_OUT;
          end
        end
        S_LOAD: begin
          mphase <= mphase + 3'd1;
          if (mphase == MUL_DONE) begin
            cv[0] <= cmd.value_a; cv[1] <= mres;
            cv[2] <= '0; cv[3] <= '0; cv[4] <= '0; cv[5] <= '0;
            pv[0] <= '0; pv[1] <= '0; pv[2] <= '0;
            pv[3] <= '0; pv[4] <= '0; pv[5] <= '0;
            j <= 3'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cmem[base + AddrW'(j)] <= cv[j];
          pmem[base + AddrW'(j)] <= pv[j];
          if (j == 3'(Terms-1)) begin
            delta_position <= '0;
            velocity <= '0;
            state <= S_OUT;
          end else j <= j + 3'd1;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/gear_predictor_corrector_per_dof_core.sv =====
`default_nettype none
// Gear six-value predictor-corrector, one Nordsieck vector per degree of
// freedom. Commands enter on start when busy is low: op selects load,
// predict or correct, dof_index picks the vector, value_a and value_b carry
// the operands. Each accepted transaction yields exactly one result on
// delta_position and velocity, marked by a one-cycle done strobe; the
// receiver cannot stall, so results are never held back.
// A front end queues up to two commands, so new transactions are taken
// while the back end works; busy is high while both queue slots are full.
// The back end reads the six terms from memory over a term-serial port,
// applies the Pascal matrix with adders or the corrector gains through one
// shared rounding multiplier (four partial products, rounding, use), writes
// the terms back and forms the velocity; a load scales value_b by time_step
// through the multiplier and writes a fresh vector. Items are handled one
// at a time. Reset empties the queue and returns the sequencer to idle;
// vector memories are not cleared and must be loaded before use.
// time_step (address 0) and inverse_step (address 8) are written through
// the APB port; the user must write them only while the block is idle, as
// the block itself does not enforce this.
module gear_predictor_corrector_per_dof_core import gpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  dof_index,
  input  wire logic [47:0] value_a,
  input  wire logic [47:0] value_b,
  output logic             done,
  output logic [47:0]      delta_position,
  output logic [47:0]      velocity,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [31:0] time_step;
  logic [46:0] inverse_step;
  logic        q_valid;
  logic        q_take;
  cmd_t        q_cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= 32'd16777;
      inverse_step <= 47'd16777216;
    end else if (psel && penable && pwrite) begin
      if (paddr == 4'd0) time_step <= pwdata[31:0];
      else if (paddr == 4'd8) inverse_step <= pwdata[46:0];
    end
  end

  always_comb begin
    if (paddr == 4'd0) prdata = {32'd0, time_step};
    else if (paddr == 4'd8) prdata = {17'd0, inverse_step};
    else prdata = '0;
  end

  gpc_front u_front (
    .clk, .rst, .start, .op, .dof_index, .value_a, .value_b,
    .busy, .q_valid, .q_cmd, .q_take
  );

  gpc_back u_back (
    .clk, .rst, .time_step, .inverse_step, .q_valid, .q_cmd, .q_take,
    .done, .delta_position, .velocity
  );

  // A command is only taken from the queue when one is there.
  assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("queue read while empty");

  // Results are single-cycle strobes from the sequencer.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");

  // The queue never reports full right after reset.
  assert property (@(posedge clk) $past(rst) |-> !busy)
    else $error("busy after reset");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  import gpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Saturation bounds of the Q24.24 datapath, held in 64-bit integers.
  localparam longint SatHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatLo = -SatHi - 1;
  localparam int TimeoutCycles = 400000;
  localparam int SettleCycles = 80;
  localparam logic [3:0] AddrStep = 4'd0;
  localparam logic [3:0] AddrInvStep = 4'd8;

  // One command as the sender presents it.
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  dof;
    logic [47:0] a;
    logic [47:0] b;
  } gear_cmd_t;

  // One result as the block should return it.
  typedef struct {
    logic [47:0] dpos;
    logic [47:0] vel;
  } gear_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [7:0]  dof_index;
  logic [47:0] value_a;
  logic [47:0] value_b;
  logic        done;
  logic [47:0] delta_position;
  logic [47:0] velocity;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  gear_predictor_corrector_per_dof_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .dof_index(dof_index), .value_a(value_a), .value_b(value_b), .done(done),
    .delta_position(delta_position), .velocity(velocity), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Commands waiting to be driven, and results the block still owes us.
  gear_cmd_t    cmd_backlog[$];
  gear_result_t owed_results[$];
  int           error_count = 0;
  int           cycle_count = 0;

  // Our own copy of the configuration and of both Nordsieck stores.
  logic [31:0]  step_q32 = 32'd16777;
  logic [46:0]  inv_step_q24 = 47'd16777216;
  longint       corr_mem[0:MaxDof*Terms-1];
  longint       pred_mem[0:MaxDof*Terms-1];
  bit           dof_loaded[0:MaxDof-1];

  function automatic longint clamp48(input longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  // Signed value times an unsigned fraction, shifted right by s, rounded to
  // nearest with ties away from zero, then saturated to 48 bits. The full
  // 128-bit product keeps the overflow check exact.
  function automatic longint scale_round(input longint x, input logic [63:0] c,
                                         input int s);
    logic [127:0] mag;
    logic [127:0] prod;
    logic         neg;
    neg = (x < 0);
    mag = {64'd0, neg ? 64'(-x) : 64'(x)};
    prod = mag * {64'd0, c};
    prod = prod + (128'd1 << (s - 1));
    prod = prod >> s;
    if (neg) begin
      if (prod > 128'h8000_0000_0000) return SatLo;
      return -longint'(prod[63:0]);
    end
    if (prod > 128'(SatHi)) return SatHi;
    return longint'(prod[63:0]);
  endfunction

  function automatic logic [63:0] corrector_gain(input int j);
    case (j)
      0: return 64'd805306368;
      1: return 64'd2994546642;
      2: return 64'h1_0000_0000;
      3: return 64'd2624702236;
      4: return 64'd715827883;
      default: return 64'd71582788;
    endcase
  endfunction

  // Applies one accepted transaction to our stores and returns what the
  // block must answer.
  function automatic gear_result_t integrate_cmd(input gear_cmd_t cmd);
    gear_result_t r;
    longint       a;
    longint       b;
    longint       acc;
    longint       err;
    longint       dpos;
    longint       vel;
    logic [63:0]  half_dt2;
    int           base;
    int           binom[6][6];
    binom = '{'{1, 1, 1, 1, 1, 1}, '{0, 1, 2, 3, 4, 5}, '{0, 0, 1, 3, 6, 10},
              '{0, 0, 0, 1, 4, 10}, '{0, 0, 0, 0, 1, 5}, '{0, 0, 0, 0, 0, 1}};
    a = longint'($signed(cmd.a));
    b = longint'($signed(cmd.b));
    base = int'(cmd.dof) * Terms;
    dpos = 0;
    vel = 0;
    case (cmd.op)
      OP_LOAD: begin
        for (int j = 0; j < Terms; j++) begin
          corr_mem[base + j] = 0;
          pred_mem[base + j] = 0;
        end
        corr_mem[base] = a;
        corr_mem[base + 1] = scale_round(b, {32'd0, step_q32}, 32);
      end
      OP_PREDICT: begin
        // Pascal matrix times the corrected vector.
        for (int j = 0; j < Terms; j++) begin
          acc = 0;
          for (int k = j; k < Terms; k++) acc += binom[j][k] * corr_mem[base + k];
          pred_mem[base + j] = clamp48(acc);
        end
        acc = 0;
        for (int j = 1; j < Terms; j++) acc += corr_mem[base + j];
        dpos = clamp48(acc);
        vel = scale_round(pred_mem[base + 1], {17'd0, inv_step_q24}, 24);
      end
      OP_CORRECT: begin
        half_dt2 = ({32'd0, step_q32} * {32'd0, step_q32}) >> 1;
        err = clamp48(scale_round(a, half_dt2, 64) - pred_mem[base + 2]);
        for (int j = 0; j < Terms; j++) begin
          if (j == 2) corr_mem[base + j] = clamp48(pred_mem[base + j] + err);
          else corr_mem[base + j] =
              clamp48(pred_mem[base + j] + scale_round(err, corrector_gain(j), 32));
        end
        dpos = scale_round(err, corrector_gain(0), 32);
        vel = scale_round(corr_mem[base + 1], {17'd0, inv_step_q24}, 24);
      end
      default: begin
      end
    endcase
    r.dpos = dpos[47:0];
    r.vel = vel[47:0];
    return r;
  endfunction

  // Driver: bursts of back-to-back commands separated by random gaps. A
  // transaction is taken at the edge where start is high and busy is low.
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    gear_cmd_t cmd;
    bit        taken;
    taken = !rst && start && !busy;
    if (taken) begin
      owed_results.push_back(integrate_cmd(cmd_backlog.pop_front()));
    end
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // Hold the command until it is taken.
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      cmd = cmd_backlog[0];
      start <= 1'b1;
      op <= cmd.op;
      dof_index <= cmd.dof;
      value_a <= cmd.a;
      value_b <= cmd.b;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        // Some bursts are followed by no gap at all.
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every done strobe must match the oldest owed result.
  always @(posedge clk) begin
    gear_result_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: delta_position=%h velocity=%h",
               delta_position, velocity);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (delta_position !== want.dpos) begin
          $error("delta_position: expected %h, actual %h", want.dpos, delta_position);
          error_count++;
        end
        if (velocity !== want.vel) begin
          $error("velocity: expected %h, actual %h", want.vel, velocity);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("** gear_predictor_corrector_per_dof_core: FAILED **");
      $finish;
    end
  end

  // Mostly moderate values, with the saturation extremes and full-range
  // noise mixed in so that every bit toggles.
  function automatic logic [47:0] pick_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2, 3: return raw[47:0];
      default: return 48'(longint'($signed(raw[31:0])) >>> $urandom_range(0, 8));
    endcase
  endfunction

  task automatic queue_cmd(input logic [1:0] o, input logic [7:0] d,
                           input logic [47:0] a, input logic [47:0] b);
    gear_cmd_t cmd;
    cmd.op = o;
    cmd.dof = d;
    cmd.a = a;
    cmd.b = b;
    if (o == OP_LOAD) dof_loaded[d] = 1'b1;
    cmd_backlog.push_back(cmd);
  endtask

  // Waits until every transaction has been taken and answered, then lets
  // the block settle before its registers change.
  task automatic drain();
    while (cmd_backlog.size() > 0 || start || owed_results.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrStep) step_q32 = data[31:0];
    else inv_step_q24 = data[46:0];
  endtask

  // Random traffic: mostly well-formed load / predict / correct sequences,
  // often on a handful of vectors so consecutive commands collide, with
  // some stray commands in between.
  task automatic queue_random(input int count);
    int          n;
    logic [7:0]  d;
    logic [1:0]  o;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 6) == 0) begin
        o = 2'($urandom_range(0, 3));
        d = 8'($urandom_range(0, 255));
        if ((o == OP_PREDICT || o == OP_CORRECT) && !dof_loaded[d]) o = OP_NONE;
        queue_cmd(o, d, pick_value(), pick_value());
        n++;
      end else begin
        d = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                        : 8'($urandom_range(0, 255));
        if (!dof_loaded[d] || $urandom_range(0, 3) == 0) begin
          queue_cmd(OP_LOAD, d, pick_value(), pick_value());
          n++;
        end
        repeat ($urandom_range(1, 4)) begin
          queue_cmd(OP_PREDICT, d, pick_value(), pick_value());
          queue_cmd(OP_CORRECT, d, pick_value(), pick_value());
          n += 2;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = OP_NONE;
    dof_index = '0;
    value_a = '0;
    value_b = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < MaxDof * Terms; i++) begin
      corr_mem[i] = 0;
      pred_mem[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: extremes of position, velocity and
    // acceleration, the end vectors, a no-op and an immediate collision.
    queue_cmd(OP_LOAD, 8'd0, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    queue_cmd(OP_PREDICT, 8'd0, 48'd0, 48'd0);
    queue_cmd(OP_CORRECT, 8'd0, 48'h7FFF_FFFF_FFFF, 48'd0);
    queue_cmd(OP_LOAD, 8'd255, 48'h8000_0000_0000, 48'h8000_0000_0000);
    queue_cmd(OP_CORRECT, 8'd255, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF);
    queue_cmd(OP_PREDICT, 8'd255, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_cmd(OP_NONE, 8'd17, 48'h1234_5678_9ABC, 48'hFFFF_0000_FFFF);
    queue_cmd(OP_LOAD, 8'd1, 48'h0000_0100_0000, 48'h0000_0200_0000);
    queue_cmd(OP_PREDICT, 8'd1, 48'd0, 48'd0);
    queue_cmd(OP_PREDICT, 8'd1, 48'd0, 48'd0);
    queue_cmd(OP_CORRECT, 8'd1, 48'h0000_0980_0000, 48'd0);
    queue_cmd(OP_PREDICT, 8'd0, 48'd0, 48'd0);
    queue_cmd(OP_CORRECT, 8'd0, 48'h8000_0000_0000, 48'd0);
    queue_cmd(OP_LOAD, 8'd0, 48'd0, 48'd0);
    queue_cmd(OP_CORRECT, 8'd0, 48'd0, 48'd0);
    queue_random(140);
    drain();

    // Both registers at zero.
    apb_write(AddrStep, 64'd0);
    apb_write(AddrInvStep, 64'd0);
    queue_random(130);
    drain();

    // Both registers at their largest values.
    apb_write(AddrStep, 64'hFFFF_FFFF);
    apb_write(AddrInvStep, 64'h7FFF_FFFF_FFFF);
    queue_random(130);
    drain();

    // A realistic step of 1/256 with its matching inverse of 256.
    apb_write(AddrStep, 64'h0100_0000);
    apb_write(AddrInvStep, 64'h1_0000_0000);
    queue_random(140);
    drain();

    // Random settings.
    repeat (2) begin
      apb_write(AddrStep, {32'd0, $urandom});
      apb_write(AddrInvStep, {17'd0, 15'($urandom), $urandom});
      queue_random(130);
      drain();
    end

    if (error_count == 0) begin
      $display("** gear_predictor_corrector_per_dof_core: PASSED **");
    end else begin
      $display("** gear_predictor_corrector_per_dof_core: FAILED **");
    end
    $finish;
  end

endmodule
